>>> design/tsf_pkg.sv
// shared constants and types for the textured span filler
package tsf_pkg;

    localparam int TEX_ADDR_BITS = 12;
    localparam int COORD_BITS    = 12;
    localparam int FRAME_WIDTH   = 1024;

    localparam int TEX_DEPTH = 1 << TEX_ADDR_BITS;

    localparam logic [11:0] COORD_MASK = 12'((33'd1 << COORD_BITS) - 33'd1);
    localparam logic [12:0] FRAME_LIMIT = 13'(FRAME_WIDTH);

    localparam logic [7:0]  BYTE_ONES = 8'hFF;
    localparam logic [16:0] SUM_LIMIT = 17'h0FFFF;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_SPAN  = 2'd1,
        MODE_PIXEL = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CFG_MODULATE = 2'd0,
        CFG_LOG2_U   = 2'd1,
        CFG_LOG2_V   = 2'd2,
        CFG_BLEND    = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_U,
        ST_DIV_V,
        ST_SHADE,
        ST_OUT
    } state_t;

    // one byte lane for the shared shade unit
    typedef struct packed {
        logic [7:0] tex;
        logic [7:0] col;
        logic [7:0] dst;
        logic [7:0] inv_a;
        logic       blend;
    } shade_in_t;

endpackage

>>> design/textured_span_fill.sv
// textured span filler top level: sequencer, texture store, span state, output word
//
// Affine texture-mapped span filler. Load words write one texel into the
// 4096-entry texture store. A span word latches row, column range and 16.16
// u/v endpoints; the u and v steps then come from one shared restoring
// divider used twice, and in_stall is high during span setup. A pixel word
// reads the texture store in its accept cycle, then the single shared byte
// shade unit works blue, green and red in turn, and the result goes to the
// output register; in_stall stays high until the result is in that register,
// so the next pixel waits for the shade unit. A new word is taken while a
// finished pixel still waits on out_stall. Texels never written read as undefined.
module textured_span_fill (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [11:0] texel_index,
    input  logic [31:0] texel_value,
    input  logic [11:0] span_row,
    input  logic [11:0] x_start,
    input  logic [11:0] x_end,
    input  logic signed [31:0] u_start,
    input  logic signed [31:0] u_end,
    input  logic signed [31:0] v_start,
    input  logic signed [31:0] v_end,
    input  logic [23:0] dest_pixel,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] pixel_x,
    output logic [11:0] pixel_y,
    output logic [23:0] pixel_color,
    output logic        span_last
);
    import tsf_pkg::*;

    // configuration
    logic [23:0] modulate_reg;
    logic [3:0]  log2_u_reg;
    logic [3:0]  log2_v_reg;
    logic        blend_reg;

    // control
    state_t      state_reg, state_next;
    logic [1:0]  byte_reg, byte_next;
    logic        active_reg, active_next;
    logic        pend_reg, pend_next;
    logic        out_valid_reg, out_valid_next;

    // span state
    logic [31:0] cur_u_reg, cur_v_reg;
    logic [31:0] step_u_reg, step_v_reg;
    logic [11:0] cur_x_reg;
    logic [12:0] stop_x_reg;
    logic [11:0] row_reg;
    logic [11:0] len_reg;
    logic [31:0] delta_v_reg;

    // per pixel
    logic [31:0] texel_reg;
    logic [23:0] dst_reg;
    logic [23:0] color_reg;
    logic [11:0] px_reg;
    logic [11:0] py_reg;
    logic        last_reg;

    // output word
    logic [11:0] out_x_reg;
    logic [11:0] out_y_reg;
    logic [23:0] out_color_reg;
    logic        out_last_reg;

    logic [31:0] tex_mem [TEX_DEPTH];

    logic        in_acc;
    logic        out_acc;
    logic        out_free;
    logic [11:0] xs, xe, len;
    logic [12:0] stop_x;
    logic [31:0] delta_u, delta_v;
    logic [15:0] mask_u, mask_v;
    logic [31:0] tu, tv;
    logic [TEX_ADDR_BITS-1:0] rd_addr;
    logic [11:0] next_x;
    logic        pixel_last;

    // strobes to the datapath
    logic        do_load, do_span, do_pixel, do_step_u, do_step_v, do_shade, do_out;

    logic        div_start;
    logic [31:0] div_dividend;
    logic [11:0] div_divisor;
    logic        div_done;
    logic [31:0] div_quot;

    shade_in_t   lane;
    logic [7:0]  shade_byte;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign xs      = x_start & COORD_MASK;
    assign xe      = x_end & COORD_MASK;
    assign len     = xe - xs;
    assign stop_x  = ({1'b0, xe} > FRAME_LIMIT) ? FRAME_LIMIT : {1'b0, xe};
    assign delta_u = u_end - u_start;
    assign delta_v = v_end - v_start;

    // wrapped texel address: u bits low, v bits above them
    assign mask_u  = 16'((17'd1 << log2_u_reg) - 17'd1);
    assign mask_v  = 16'((17'd1 << log2_v_reg) - 17'd1);
    assign tu      = {16'd0, cur_u_reg[31:16] & mask_u};
    assign tv      = {16'd0, cur_v_reg[31:16] & mask_v} << log2_u_reg;
    assign rd_addr = TEX_ADDR_BITS'(tu | tv);

    assign next_x     = cur_x_reg + 12'd1;
    assign pixel_last = {1'b0, next_x} >= stop_x_reg;

    always_comb
    begin
        state_next   = state_reg;
        byte_next    = byte_reg;
        active_next  = active_reg;
        pend_next    = pend_reg;
        do_load      = 1'b0;
        do_span      = 1'b0;
        do_pixel     = 1'b0;
        do_step_u    = 1'b0;
        do_step_v    = 1'b0;
        do_shade     = 1'b0;
        do_out       = 1'b0;
        div_start    = 1'b0;
        div_dividend = delta_u;
        div_divisor  = len;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (mode)
                        MODE_LOAD:
                        begin
                            do_load = 1'b1;
                        end
                        MODE_SPAN:
                        begin
                            active_next = 1'b0;
                            if (xe > xs)
                            begin
                                do_span    = 1'b1;
                                div_start  = 1'b1;
                                pend_next  = {1'b0, xs} < stop_x;
                                state_next = ST_DIV_U;
                            end
                        end
                        MODE_PIXEL:
                        begin
                            if (active_reg)
                            begin
                                do_pixel    = 1'b1;
                                active_next = !pixel_last;
                                byte_next   = 2'd0;
                                state_next  = ST_SHADE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV_U:
            begin
                div_dividend = delta_v_reg;
                div_divisor  = len_reg;
                if (div_done)
                begin
                    do_step_u  = 1'b1;
                    div_start  = 1'b1;
                    state_next = ST_DIV_V;
                end
            end
            ST_DIV_V:
            begin
                div_dividend = delta_v_reg;
                div_divisor  = len_reg;
                if (div_done)
                begin
                    do_step_v   = 1'b1;
                    active_next = pend_reg;
                    state_next  = ST_IDLE;
                end
            end
            ST_SHADE:
            begin
                do_shade = 1'b1;
                if (byte_reg == 2'd2)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    byte_next = byte_reg + 2'd1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    do_out     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_acc)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    tsf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        lane.tex   = texel_reg[byte_reg*8 +: 8];
        lane.col   = modulate_reg[byte_reg*8 +: 8];
        lane.dst   = dst_reg[byte_reg*8 +: 8];
        lane.inv_a = texel_reg[31:24] ^ BYTE_ONES;
        lane.blend = blend_reg;
    end

    tsf_shade u_shade (
        .lane   (lane),
        .result (shade_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            byte_reg      <= '0;
            active_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            modulate_reg  <= 24'hFFFFFF;
            log2_u_reg    <= 4'd6;
            log2_v_reg    <= 4'd6;
            blend_reg     <= 1'b0;
            cur_u_reg     <= '0;
            cur_v_reg     <= '0;
            step_u_reg    <= '0;
            step_v_reg    <= '0;
            cur_x_reg     <= '0;
            stop_x_reg    <= '0;
            row_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_reg      <= byte_next;
            active_reg    <= active_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODULATE: modulate_reg <= cfg_data;
                    CFG_LOG2_U:   log2_u_reg   <= cfg_data[3:0];
                    CFG_LOG2_V:   log2_v_reg   <= cfg_data[3:0];
                    CFG_BLEND:    blend_reg    <= cfg_data[0];
                    default:      blend_reg    <= blend_reg;
                endcase
            end

            if (do_span)
            begin
                cur_u_reg  <= u_start;
                cur_v_reg  <= v_start;
                row_reg    <= span_row & COORD_MASK;
                cur_x_reg  <= xs;
                stop_x_reg <= stop_x;
            end
            else if (do_pixel)
            begin
                cur_u_reg <= cur_u_reg + step_u_reg;
                cur_v_reg <= cur_v_reg + step_v_reg;
                cur_x_reg <= next_x;
            end

            if (do_step_u)
            begin
                step_u_reg <= div_quot;
            end
            if (do_step_v)
            begin
                step_v_reg <= div_quot;
            end
        end
    end

    // texture store, read data registered
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            tex_mem[TEX_ADDR_BITS'(texel_index)] <= texel_value;
        end
        if (do_pixel)
        begin
            texel_reg <= tex_mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (do_span)
        begin
            len_reg     <= len;
            delta_v_reg <= delta_v;
        end
        if (do_pixel)
        begin
            dst_reg  <= dest_pixel;
            px_reg   <= cur_x_reg;
            py_reg   <= row_reg;
            last_reg <= pixel_last;
        end
        if (do_shade)
        begin
            color_reg[byte_reg*8 +: 8] <= shade_byte;
        end
        if (do_out)
        begin
            out_x_reg     <= px_reg;
            out_y_reg     <= py_reg;
            out_color_reg <= color_reg;
            out_last_reg  <= last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign pixel_color = out_color_reg;
    assign span_last   = out_last_reg;

endmodule

>>> design/tsf_divider.sv
// iterative signed-by-unsigned divider, one quotient bit per cycle, truncating
module tsf_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [11:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import tsf_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [31:0] quo_reg, quo_next;
    logic [11:0] rem_reg, rem_next;
    logic [11:0] dsr_reg, dsr_next;

    logic [12:0] shifted;
    logic [12:0] diff;
    logic        fits;

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[31];
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[11:0] : shifted[11:0];
            quo_next = {quo_reg[30:0], fits};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

>>> design/tsf_shade.sv
// shared byte shade unit: modulate, optional alpha blend, saturate
module tsf_shade (
    input  tsf_pkg::shade_in_t lane,
    output logic [7:0]         result
);
    import tsf_pkg::*;

    logic [15:0] mod_prod;
    logic [15:0] dst_prod;
    logic [16:0] sum;
    logic [15:0] clipped;

    assign mod_prod = lane.tex * lane.col;
    assign dst_prod = lane.dst * lane.inv_a;
    assign sum      = {1'b0, mod_prod} + (lane.blend ? {1'b0, dst_prod} : 17'd0);
    assign clipped  = (sum > SUM_LIMIT) ? SUM_LIMIT[15:0] : sum[15:0];
    assign result   = clipped[15:8];

endmodule
